>>> design/keypad_debounce_hold_detect_assert.svh
// Assertion macros for the keypad debounce block.
// Pulled into the top-level design file by include; no other dependencies.
`ifndef KEYPAD_DEBOUNCE_HOLD_DETECT_ASSERT_SVH
`define KEYPAD_DEBOUNCE_HOLD_DETECT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define KDH_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keypad debounce check failed");

// Next-cycle implication, disabled while reset is low
`define KDH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keypad debounce check failed");

`endif

>>> design/kdh_pkg.sv
// Shared types and constants of the keypad debounce and hold detector.
// No dependencies; imported by the interfaces and all modules.
package kdh_pkg;

    localparam int KEY_W   = 5;
    localparam int AUX_W   = 4;
    localparam int COMBO_W = 8;
    localparam int STEP_W  = 16;
    localparam int SIZE_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Key bit positions, active low
    localparam int KEY_UP    = 0;
    localparam int KEY_RIGHT = 1;
    localparam int KEY_ENTER = 2;
    localparam int KEY_LEFT  = 3;
    localparam int KEY_DOWN  = 4;

    localparam logic [SIZE_W-1:0]  STEP_FINE   = 7'd10;
    localparam logic [SIZE_W-1:0]  STEP_COARSE = 7'd100;

    localparam logic [COMBO_W-1:0] COMBO_LIMIT_RST  = 8'd170;
    localparam logic [STEP_W-1:0]  STEP_LIMIT_RST   = 16'd200;
    localparam logic [AUX_W-1:0]   TEST_PATTERN_RST = 4'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COMBO_LIMIT  = 2'd0,
        CFG_STEP_LIMIT   = 2'd1,
        CFG_TEST_PATTERN = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [COMBO_W-1:0] combo_limit;
        logic [STEP_W-1:0]  step_limit;
        logic [AUX_W-1:0]   test_pattern;
    } t_kdh_cfg;

    typedef struct packed {
        logic              fault_mode;
        logic              test_mode;
        logic [SIZE_W-1:0] step_size;
    } t_kdh_flags;

endpackage

>>> design/kdh_if.sv
// Valid/ready channel interfaces: tick input, result output, register writes.
// Depends on kdh_pkg for field widths.
interface kdh_in_if
    import kdh_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_sample;
    logic [AUX_W-1:0] aux_inputs;

    modport source (output valid, output key_sample, output aux_inputs, input ready);
    modport sink   (input valid, input key_sample, input aux_inputs, output ready);
endinterface

interface kdh_out_if
    import kdh_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [KEY_W-1:0]  keys_debounced;
    logic [KEY_W-1:0]  key_pressed;
    logic              fault_mode;
    logic              test_mode;
    logic [SIZE_W-1:0] step_size;

    modport source (output valid, output keys_debounced, output key_pressed,
                    output fault_mode, output test_mode, output step_size, input ready);
    modport sink   (input valid, input keys_debounced, input key_pressed,
                    input fault_mode, input test_mode, input step_size, output ready);
endinterface

interface kdh_cfg_if
    import kdh_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/kdh_debounce.sv
// Vertical-counter debouncer for the five keys, with press edge detection.
// Depends on kdh_pkg.
module kdh_debounce
    import kdh_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [KEY_W-1:0] i_sample,
    output logic [KEY_W-1:0] o_keys,
    output logic [KEY_W-1:0] o_pressed
);

    logic             r_loaded;
    logic [KEY_W-1:0] r_deb;
    logic [KEY_W-1:0] r_c0;
    logic [KEY_W-1:0] r_c1;
    logic [KEY_W-1:0] r_c2;

    logic [KEY_W-1:0] w_base;
    logic [KEY_W-1:0] w_delta;
    logic [KEY_W-1:0] n_c0;
    logic [KEY_W-1:0] n_c1;
    logic [KEY_W-1:0] n_c2;
    logic [KEY_W-1:0] n_deb;

    // Load the sample on the first tick, then count differing samples
    always_comb begin
        w_base  = r_loaded ? r_deb : i_sample;
        w_delta = i_sample ^ w_base;
        n_c2    = (r_c2 ^ (r_c1 & r_c0)) & w_delta;
        n_c1    = (r_c1 ^ r_c0) & w_delta;
        n_c0    = ~r_c0 & w_delta;
        n_deb   = w_base ^ (n_c0 & n_c1 & n_c2);
    end

    // The held debounced level doubles as the previous tick's level
    assign o_keys    = n_deb;
    assign o_pressed = r_deb & ~n_deb;

    // Advance the counters once per processed tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= 1'b0;
            r_deb    <= '0;
            r_c0     <= '0;
            r_c1     <= '0;
            r_c2     <= '0;
        end else if (i_en) begin
            r_loaded <= 1'b1;
            r_deb    <= n_deb;
            r_c0     <= n_c0;
            r_c1     <= n_c1;
            r_c2     <= n_c2;
        end
    end

endmodule

>>> design/kdh_hold.sv
// Long-hold detection: fault-menu and test toggles, step size alternation.
// Depends on kdh_pkg.
module kdh_hold
    import kdh_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [KEY_W-1:0] i_keys,
    input  logic [AUX_W-1:0] i_aux,
    input  t_kdh_cfg         i_cfg,
    output t_kdh_flags       o_flags
);

    logic [COMBO_W-1:0] r_fault_cnt;
    logic [COMBO_W-1:0] r_test_cnt;
    logic [STEP_W-1:0]  r_step_cnt;
    logic               r_fault;
    logic               r_test;
    logic [SIZE_W-1:0]  r_step;

    logic [COMBO_W-1:0] n_fault_cnt;
    logic [COMBO_W-1:0] n_test_cnt;
    logic [STEP_W-1:0]  n_step_cnt;
    logic [STEP_W-1:0]  w_step_inc;
    logic               n_fault;
    logic               n_test;
    logic [SIZE_W-1:0]  n_step;
    logic               w_lr_held;
    logic               w_ud_held;
    logic               w_any_ud;

    always_comb begin
        w_lr_held = !i_keys[KEY_LEFT] && !i_keys[KEY_RIGHT];
        w_ud_held = !i_keys[KEY_UP] && !i_keys[KEY_DOWN];
        w_any_ud  = !i_keys[KEY_UP] || !i_keys[KEY_DOWN];

        // Fault menu: left plus right held past the combo limit
        n_fault     = r_fault;
        n_fault_cnt = '0;
        if (w_lr_held) begin
            if (r_fault_cnt > i_cfg.combo_limit) begin
                n_fault = ~r_fault;
            end else begin
                n_fault_cnt = r_fault_cnt + 1'b1;
            end
        end

        // Test mode: up plus down held with the aux pattern present
        n_test     = r_test;
        n_test_cnt = '0;
        if (w_ud_held && (i_aux == i_cfg.test_pattern)) begin
            if (r_test_cnt > i_cfg.combo_limit) begin
                n_test = ~r_test;
            end else begin
                n_test_cnt = r_test_cnt + 1'b1;
            end
        end

        // Step size: count first, then compare against the limit
        w_step_inc = w_any_ud ? (r_step_cnt + 1'b1) : '0;
        n_step     = r_step;
        n_step_cnt = w_step_inc;
        if (w_step_inc > i_cfg.step_limit) begin
            n_step     = (r_step == STEP_FINE) ? STEP_COARSE : STEP_FINE;
            n_step_cnt = '0;
        end
    end

    assign o_flags.fault_mode = n_fault;
    assign o_flags.test_mode  = n_test;
    assign o_flags.step_size  = n_step;

    // Hold counters and flags per processed tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault_cnt <= '0;
            r_test_cnt  <= '0;
            r_step_cnt  <= '0;
            r_fault     <= 1'b0;
            r_test      <= 1'b0;
            r_step      <= '0;
        end else if (i_en) begin
            r_fault_cnt <= n_fault_cnt;
            r_test_cnt  <= n_test_cnt;
            r_step_cnt  <= n_step_cnt;
            r_fault     <= n_fault;
            r_test      <= n_test;
            r_step      <= n_step;
        end
    end

endmodule

>>> design/keypad_debounce_hold_detect.sv
// Top level of the keypad debounce and hold detector: channel registers,
// configuration registers. Depends on kdh_pkg, kdh_if, kdh_debounce, kdh_hold.
//
//  channel  | dir | transaction                      | fields
//  ---------+-----+----------------------------------+---------------------------------
//  i_in     | in  | one 10 ms tick                   | key_sample, aux_inputs
//  o_res    | out | one result per tick              | keys_debounced, key_pressed,
//           |     |                                  | fault_mode, test_mode, step_size
//  i_cfg    | in  | one register write, always ready | index, data
//
// One tick per clock sustained while o_res is not stalled. An accepted tick lands in the
// input register and its result is loaded into the result register once that register is
// free, so o_res.valid follows the input register; the debounce and hold logic sits
// between the two registers. Reset (i_rst_n low, synchronous) empties both registers,
// clears all key state and loads the register defaults. While o_res is stalled the
// input register still takes one more tick before i_in.ready drops.
`include "keypad_debounce_hold_detect_assert.svh"

module keypad_debounce_hold_detect
    import kdh_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    kdh_in_if.sink   i_in,
    kdh_out_if.source o_res,
    kdh_cfg_if.sink  i_cfg
);

    t_kdh_cfg         r_cfg;
    logic             r_in_valid;
    logic [KEY_W-1:0] r_in_keys;
    logic [AUX_W-1:0] r_in_aux;
    logic             r_out_valid;
    logic [KEY_W-1:0] r_out_keys;
    logic [KEY_W-1:0] r_out_pressed;
    t_kdh_flags       r_out_flags;

    logic             w_out_free;
    logic             w_adv;
    logic [KEY_W-1:0] w_keys;
    logic [KEY_W-1:0] w_pressed;
    t_kdh_flags       w_flags;
    logic             w_press_ok;
    logic             w_step_ok;
    logic             w_full_stall;

    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_adv      = r_in_valid && w_out_free;
    assign i_in.ready = !r_in_valid || w_out_free;
    assign i_cfg.ready = 1'b1;

    // Register writes; an unknown index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.combo_limit  <= COMBO_LIMIT_RST;
            r_cfg.step_limit   <= STEP_LIMIT_RST;
            r_cfg.test_pattern <= TEST_PATTERN_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_COMBO_LIMIT:  r_cfg.combo_limit  <= i_cfg.data[COMBO_W-1:0];
                CFG_STEP_LIMIT:   r_cfg.step_limit   <= i_cfg.data[STEP_W-1:0];
                CFG_TEST_PATTERN: r_cfg.test_pattern <= i_cfg.data[AUX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Capture the incoming tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_keys <= i_in.key_sample;
            r_in_aux  <= i_in.aux_inputs;
        end
    end

    kdh_debounce u_debounce (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_adv),
        .i_sample  (r_in_keys),
        .o_keys    (w_keys),
        .o_pressed (w_pressed)
    );

    kdh_hold u_hold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_keys  (w_keys),
        .i_aux   (r_in_aux),
        .i_cfg   (r_cfg),
        .o_flags (w_flags)
    );

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_keys    <= w_keys;
            r_out_pressed <= w_pressed;
            r_out_flags   <= w_flags;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.keys_debounced = r_out_keys;
    assign o_res.key_pressed    = r_out_pressed;
    assign o_res.fault_mode     = r_out_flags.fault_mode;
    assign o_res.test_mode      = r_out_flags.test_mode;
    assign o_res.step_size      = r_out_flags.step_size;

    // Terms checked by the assertions below
    assign w_press_ok   = (r_out_pressed & r_out_keys) == '0;
    assign w_step_ok    = (r_out_flags.step_size == '0) ||
                          (r_out_flags.step_size == STEP_FINE) ||
                          (r_out_flags.step_size == STEP_COARSE);
    assign w_full_stall = r_in_valid && r_out_valid && !o_res.ready;

    // A processed tick always leaves a result behind
    `KDH_ASSERT_NEXT(a_adv_gives_result, i_clk, i_rst_n, w_adv, r_out_valid)
    // A reported press must read as pressed in the same result
    `KDH_ASSERT_IMPLY(a_press_is_low, i_clk, i_rst_n, r_out_valid, w_press_ok)
    // Step size only ever takes its three legal values
    `KDH_ASSERT_IMPLY(a_step_legal, i_clk, i_rst_n, r_out_valid, w_step_ok)
    // A stalled result with a full input register blocks new ticks
    `KDH_ASSERT_NEXT(a_stall_holds_input, i_clk, i_rst_n, w_full_stall, r_in_valid)

endmodule
